// ----- hw/rtl/tpc_pkg.sv -----
package tpc_pkg;

    localparam int unsigned CmdW    = 1;
    localparam int unsigned SampleW = 20;
    localparam int unsigned ResW    = 32;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgW    = 64;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_TEMP_TRIM  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_PRESS_LOW  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_PRESS_MID  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_PRESS_HIGH = 3'd3;

    // command / result kind codes
    localparam logic CMD_TEMP  = 1'b0;
    localparam logic CMD_PRESS = 1'b1;

    // formula constants
    localparam logic [63:0] FINE_OFFSET = 64'd128000;
    localparam logic [63:0] ADC_FULL    = 64'd1048576;
    localparam logic [63:0] SCALE_3125  = 64'd3125;
    localparam logic [63:0] ROUND_47    = 64'd1 << 47;

    // control beat to the shared multiplier
    typedef struct packed {
        logic start;
        logic short_mode;   // b is a signed 17-bit operand, one pass
    } mul_ctl_t;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        sx16 = {{48{v[15]}}, v};
    endfunction

endpackage

// ----- hw/rtl/temp_press_compensation.sv -----
// Channel  Direction  Signals
// in       sink       in_valid, in_ready, cmd, raw_sample
// out      source     out_valid, out_ready, result_kind, temperature, pressure,
//                     divisor_zero
// cfg      sink       cfg_valid, cfg_ready, cfg_index, cfg_data
//
// One item at a time: the time from accept to result is set by the shared 64x17
// multiplier (1 pass for a signed 17-bit operand, 4 passes on 64x64 products,
// low 64 bits kept) and the restoring divider, which a pressure beat with a zero
// divisor skips.
// Reset clears trims, fine temperature and all control; cfg is always ready.
// A finished result waits in the output register; a new beat is taken while
// it waits, and the sequencer holds its last step only if a second result is due.
module temp_press_compensation (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tpc_pkg::CmdW-1:0]       cmd,
    input  logic [tpc_pkg::SampleW-1:0]    raw_sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           result_kind,
    output logic signed [tpc_pkg::ResW-1:0] temperature,
    output logic [tpc_pkg::ResW-1:0]       pressure,
    output logic                           divisor_zero,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tpc_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [tpc_pkg::CfgW-1:0]       cfg_data
);
    import tpc_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_T0   = 4'd1;
    localparam logic [3:0] S_T1   = 4'd2;
    localparam logic [3:0] S_T2   = 4'd3;
    localparam logic [3:0] S_P0   = 4'd4;
    localparam logic [3:0] S_P1   = 4'd5;
    localparam logic [3:0] S_P2   = 4'd6;
    localparam logic [3:0] S_P3   = 4'd7;
    localparam logic [3:0] S_P4   = 4'd8;
    localparam logic [3:0] S_P5   = 4'd9;
    localparam logic [3:0] S_P6   = 4'd10;
    localparam logic [3:0] S_P7   = 4'd11;
    localparam logic [3:0] S_P8   = 4'd12;
    localparam logic [3:0] S_P9   = 4'd13;
    localparam logic [3:0] S_P10  = 4'd14;
    localparam logic [3:0] S_FIN  = 4'd15;

    logic [3:0]   step_reg;
    logic         issued_reg;
    logic         kind_reg;
    logic [19:0]  adc_reg;
    logic [31:0]  fine_reg;
    logic [63:0]  x_reg;
    logic [63:0]  sq_reg;
    logic [63:0]  v2_reg;
    logic [63:0]  t_reg;
    logic [63:0]  den_reg;
    logic [63:0]  num_reg;
    logic [63:0]  q_reg;
    logic         zero_reg;

    logic [47:0]  temp_trim_reg;
    logic [63:0]  press_low_reg;
    logic [63:0]  press_mid_reg;
    logic [15:0]  press_high_reg;

    logic         out_valid_reg;
    logic         result_kind_reg;
    logic [31:0]  temperature_reg;
    logic [31:0]  pressure_reg;
    logic         divisor_zero_reg;

    mul_ctl_t     mul_ctl;
    logic [63:0]  mul_a;
    logic [63:0]  mul_b;
    logic         mul_done;
    logic [63:0]  mul_prod;
    logic         div_start;
    logic         div_done;
    logic [63:0]  div_quot;

    logic [15:0]  t1;
    logic [31:0]  a32;
    logic [31:0]  d32;
    logic [63:0]  qs13;
    logic [63:0]  den_new;
    logic [63:0]  pv;
    logic [31:0]  tsum;
    logic [63:0]  psum;
    logic [63:0]  pfin;
    logic         fin_go;

    assign t1   = temp_trim_reg[15:0];
    assign a32  = {15'd0, adc_reg[19:3]} - {15'd0, t1, 1'b0};
    assign d32  = {16'd0, adc_reg[19:4]} - {16'd0, t1};
    assign qs13 = 64'($signed(q_reg) >>> 13);
    assign pv   = ADC_FULL - {44'd0, adc_reg};
    assign den_new = 64'($signed(mul_prod) >>> 33);

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_ctl.start = !issued_reg && (step_reg != S_IDLE) && (step_reg != S_P7)
                        && (step_reg != S_FIN);
        mul_a = x_reg;
        mul_b = x_reg;
        mul_ctl.short_mode = 1'b1;
        case (step_reg)
            S_T0:  begin mul_a = {32'd0, a32};         mul_b = sx16(temp_trim_reg[31:16]); end
            S_T1:  begin mul_a = {32'd0, d32};         mul_b = {32'd0, d32};
                         mul_ctl.short_mode = 1'b0; end
            S_T2:  begin mul_a = {32'd0, sq_reg[31:0]}; mul_b = sx16(temp_trim_reg[47:32]); end
            S_P0:  begin mul_a = x_reg;  mul_b = x_reg; mul_ctl.short_mode = 1'b0; end
            S_P1:  begin mul_a = sq_reg; mul_b = sx16(press_mid_reg[31:16]); end
            S_P2:  begin mul_a = x_reg;  mul_b = sx16(press_mid_reg[15:0]); end
            S_P3:  begin mul_a = sq_reg; mul_b = sx16(press_low_reg[47:32]); end
            S_P4:  begin mul_a = x_reg;  mul_b = sx16(press_low_reg[31:16]); end
            S_P5:  begin mul_a = t_reg;  mul_b = {48'd0, press_low_reg[15:0]}; end
            S_P6:  begin mul_a = (pv << 31) - v2_reg; mul_b = SCALE_3125; end
            S_P8:  begin mul_a = qs13;   mul_b = sx16(press_high_reg); end
            S_P9:  begin mul_a = t_reg;  mul_b = qs13; mul_ctl.short_mode = 1'b0; end
            S_P10: begin mul_a = q_reg;  mul_b = sx16(press_mid_reg[63:48]); end
            default: ;
        endcase
    end

    assign div_start     = !issued_reg && (step_reg == S_P7);

    tpc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    tpc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // final results
    assign tsum   = {fine_reg[29:0], 2'b00} + fine_reg + 32'd128;
    assign psum   = q_reg + v2_reg;
    assign pfin   = 64'($signed(psum) >>> 8) + (sx16(press_mid_reg[47:32]) << 4);
    assign fin_go = (step_reg == S_FIN) && (!out_valid_reg || out_ready);

    assign in_ready  = (step_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= S_IDLE;
            issued_reg <= 1'b0;
            fine_reg   <= 32'd0;
            zero_reg   <= 1'b0;
            kind_reg   <= CMD_TEMP;
        end
        else
        begin
            unique case (step_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        kind_reg <= cmd[0];
                        zero_reg <= 1'b0;
                        step_reg <= (cmd[0] == CMD_PRESS) ? S_P0 : S_T0;
                    end
                end
                S_FIN:
                begin
                    if (fin_go)
                        step_reg <= S_IDLE;
                end
                S_P7:
                begin
                    if (!issued_reg)
                        issued_reg <= 1'b1;
                    else if (div_done)
                    begin
                        issued_reg <= 1'b0;
                        step_reg   <= S_P8;
                    end
                end
                default:
                begin
                    if (!issued_reg)
                        issued_reg <= 1'b1;
                    else if (mul_done)
                    begin
                        issued_reg <= 1'b0;
                        if (step_reg == S_T2)
                        begin
                            fine_reg <= t_reg[31:0]
                                        + 32'($signed(mul_prod[31:0]) >>> 14);
                            step_reg <= S_FIN;
                        end
                        else if (step_reg == S_P5 && den_new == 64'd0)
                        begin
                            zero_reg <= 1'b1;
                            step_reg <= S_FIN;
                        end
                        else
                            step_reg <= step_reg + 4'd1;
                    end
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (step_reg == S_IDLE && in_valid)
            adc_reg <= raw_sample;
        if (step_reg == S_IDLE)
            x_reg <= {{32{fine_reg[31]}}, fine_reg} - FINE_OFFSET;
        if (step_reg == S_P7 && div_done)
            q_reg <= div_quot;
        if (issued_reg && mul_done)
        begin
            case (step_reg)
                S_T0:  t_reg  <= {32'd0, 32'($signed(mul_prod[31:0]) >>> 11)};
                S_T1:  sq_reg <= {32'd0, 32'($signed(mul_prod[31:0]) >>> 12)};
                S_P0:  sq_reg <= mul_prod;
                S_P1:  v2_reg <= mul_prod;
                S_P2:  v2_reg <= v2_reg + (mul_prod << 17)
                                 + (sx16(press_low_reg[63:48]) << 35);
                S_P3:  t_reg  <= 64'($signed(mul_prod) >>> 8);
                S_P4:  t_reg  <= t_reg + (mul_prod << 12) + ROUND_47;
                S_P5:  den_reg <= den_new;
                S_P6:  num_reg <= mul_prod;
                S_P8:  t_reg  <= mul_prod;
                S_P9:  t_reg  <= 64'($signed(mul_prod) >>> 25);
                S_P10: v2_reg <= t_reg + 64'($signed(mul_prod) >>> 19);
                default: ;
            endcase
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_trim_reg  <= 48'd0;
            press_low_reg  <= 64'd0;
            press_mid_reg  <= 64'd0;
            press_high_reg <= 16'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TEMP_TRIM:  temp_trim_reg  <= cfg_data[47:0];
                REG_PRESS_LOW:  press_low_reg  <= cfg_data;
                REG_PRESS_MID:  press_mid_reg  <= cfg_data;
                REG_PRESS_HIGH: press_high_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fin_go)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            result_kind_reg <= kind_reg;
            if (kind_reg == CMD_TEMP)
            begin
                temperature_reg  <= 32'($signed(tsum) >>> 8);
                pressure_reg     <= 32'd0;
                divisor_zero_reg <= 1'b0;
            end
            else
            begin
                temperature_reg  <= 32'd0;
                pressure_reg     <= zero_reg ? 32'd0 : pfin[31:0];
                divisor_zero_reg <= zero_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = result_kind_reg;
    assign temperature  = temperature_reg;
    assign pressure     = pressure_reg;
    assign divisor_zero = divisor_zero_reg;

endmodule

// ----- hw/rtl/tpc_mul.sv -----
module tpc_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  tpc_pkg::mul_ctl_t  ctl,
    input  logic [63:0]        a,
    input  logic [63:0]        b,
    output logic               done,
    output logic [63:0]        prod
);
    import tpc_pkg::*;

    logic               busy_reg;
    logic               short_reg;
    logic               done_reg;
    logic [1:0]         cnt_reg;
    logic [63:0]        a_reg;
    logic [63:0]        b_reg;
    logic [63:0]        acc_reg;
    logic signed [16:0] chunk;
    logic signed [80:0] part;
    logic [63:0]        part_sh;
    logic               last;

    // one 64x17 signed partial product per cycle, low 64 bits kept
    always_comb
    begin
        if (short_reg)
            chunk = $signed(b_reg[16:0]);
        else
            chunk = $signed({1'b0, b_reg[{cnt_reg, 4'b0000} +: 16]});
    end

    assign part    = $signed(a_reg) * chunk;
    assign part_sh = part[63:0] << {cnt_reg, 4'b0000};
    assign last    = short_reg || (cnt_reg == 2'd3);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (last)
                    busy_reg <= 1'b0;
            end
        end
    end

    // operands and accumulator
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            a_reg     <= a;
            b_reg     <= b;
            short_reg <= ctl.short_mode;
            acc_reg   <= 64'd0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + part_sh;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ----- hw/rtl/tpc_div.sv -----
module tpc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] quot
);
    import tpc_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg;
    logic [63:0] ub_reg;
    logic [63:0] rem_reg;
    logic [63:0] q_reg;
    logic [63:0] quot_reg;
    logic [64:0] rem_sh;
    logic [64:0] rem_sub;
    logic        fits;

    // one restoring step per cycle on magnitudes
    assign rem_sh  = {rem_reg, q_reg[63]};
    assign rem_sub = rem_sh - {1'b0, ub_reg};
    assign fits    = !rem_sub[64];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 6'd63);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[63] ^ den[63];
            q_reg   <= num[63] ? (64'd0 - num) : num;
            ub_reg  <= den[63] ? (64'd0 - den) : den;
            rem_reg <= 64'd0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub[63:0] : rem_sh[63:0];
            q_reg   <= {q_reg[62:0], fits};
            if (cnt_reg == 6'd63)
                quot_reg <= neg_reg ? (64'd0 - {q_reg[62:0], fits})
                                    : {q_reg[62:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- tb/sv/temp_press_compensation_test.sv -----
module temp_press_compensation_test;
    import tpc_pkg::*;

    // one expected result beat
    typedef struct packed {
        logic        kind;
        logic [31:0] temp;
        logic [31:0] press;
        logic        dz;
    } comp_result_t;

    // scoreboard: predicts compensation results and matches them in order
    class comp_scoreboard;
        logic [47:0]    temp_trim;
        logic [63:0]    press_low;
        logic [63:0]    press_mid;
        logic [15:0]    press_high;
        logic [31:0]    fine_temp;
        comp_result_t   pending[$];
        int             n_errors;
        int             n_checked;

        function void clear();
            temp_trim = '0;
            press_low = '0;
            press_mid = '0;
            press_high = '0;
            fine_temp = '0;
            pending.delete();
            n_errors = 0;
            n_checked = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] data);
            case (idx)
                REG_TEMP_TRIM:  temp_trim = data[47:0];
                REG_PRESS_LOW:  press_low = data;
                REG_PRESS_MID:  press_mid = data;
                REG_PRESS_HIGH: press_high = data[15:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] calc_temp(logic [19:0] adc);
            logic signed [31:0] t1;
            logic signed [31:0] t2;
            logic signed [31:0] t3;
            logic signed [31:0] a;
            logic signed [31:0] d;
            logic signed [31:0] v1;
            logic signed [31:0] v2;
            logic signed [31:0] sq;
            logic signed [31:0] f5;
            t1 = {16'd0, temp_trim[15:0]};
            t2 = {{16{temp_trim[31]}}, temp_trim[31:16]};
            t3 = {{16{temp_trim[47]}}, temp_trim[47:32]};
            a = {15'd0, adc[19:3]} - (t1 << 1);
            v1 = (a * t2) >>> 11;
            d = {16'd0, adc[19:4]} - t1;
            sq = (d * d) >>> 12;
            v2 = (sq * t3) >>> 14;
            fine_temp = v1 + v2;
            f5 = $signed(fine_temp) * 5 + 128;
            return f5 >>> 8;
        endfunction

        function logic [31:0] calc_press(logic [19:0] adc, output logic dz);
            logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
            logic signed [63:0] v1;
            logic signed [63:0] v2;
            logic signed [63:0] p;
            logic signed [63:0] num;
            logic        [63:0] ua;
            logic        [63:0] ub;
            logic        [63:0] q;
            p1 = {48'd0, press_low[15:0]};
            p2 = {{48{press_low[31]}}, press_low[31:16]};
            p3 = {{48{press_low[47]}}, press_low[47:32]};
            p4 = {{48{press_low[63]}}, press_low[63:48]};
            p5 = {{48{press_mid[15]}}, press_mid[15:0]};
            p6 = {{48{press_mid[31]}}, press_mid[31:16]};
            p7 = {{48{press_mid[47]}}, press_mid[47:32]};
            p8 = {{48{press_mid[63]}}, press_mid[63:48]};
            p9 = {{48{press_high[15]}}, press_high};
            v1 = {{32{fine_temp[31]}}, fine_temp} - 64'sd128000;
            v2 = v1 * v1 * p6;
            v2 = v2 + ((v1 * p5) << 17);
            v2 = v2 + (p4 << 35);
            v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) << 12);
            v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
            dz = (v1 == 0);
            if (dz)
                return 32'd0;
            p = 64'sd1048576 - {44'd0, adc};
            num = ((p << 31) - v2) * 64'sd3125;
            // signed truncating divide; min / -1 wraps
            ua = num[63] ? -num : num;
            ub = v1[63] ? -v1 : v1;
            q = ua / ub;
            p = (num[63] != v1[63]) ? -q : q;
            v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
            v2 = (p8 * p) >>> 19;
            p = ((p + v1 + v2) >>> 8) + (p7 << 4);
            return p[31:0];
        endfunction

        function void note_input(logic c, logic [19:0] adc);
            comp_result_t r;
            r = '0;
            r.kind = c;
            if (c == CMD_TEMP)
                r.temp = calc_temp(adc);
            else
                r.press = calc_press(adc, r.dz);
            pending.push_back(r);
        endfunction

        function void check_result(comp_result_t got);
            comp_result_t exp_r;
            n_checked++;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat kind=%0d", got.kind);
                n_errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.kind !== exp_r.kind)
            begin
                $error("result_kind exp %0d got %0d", exp_r.kind, got.kind);
                n_errors++;
            end
            if (got.temp !== exp_r.temp)
            begin
                $error("temperature exp %0d got %0d", $signed(exp_r.temp),
                       $signed(got.temp));
                n_errors++;
            end
            if (got.press !== exp_r.press)
            begin
                $error("pressure exp %h got %h", exp_r.press, got.press);
                n_errors++;
            end
            if (got.dz !== exp_r.dz)
            begin
                $error("divisor_zero exp %0d got %0d", exp_r.dz, got.dz);
                n_errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        cmd;
    logic [19:0] raw_sample;
    logic        out_valid;
    logic        out_ready;
    logic        result_kind;
    logic signed [31:0] temperature;
    logic [31:0] pressure;
    logic        divisor_zero;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    comp_scoreboard sb;
    int  cycle_count;
    bit  hold_off;
    int  n_temp;
    int  n_press;
    int  n_dz;

    temp_press_compensation uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .raw_sample(raw_sample),
        .out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
        .temperature(temperature), .pressure(pressure), .divisor_zero(divisor_zero),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return 0;
        if (r < 92)
            return $urandom_range(3);
        return $urandom_range(60, 10);
    endfunction

    // global watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("temp_press_compensation_test: FAIL");
            $finish;
        end
    end

    // result side: random stalls plus an optional long hold-off
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_ready <= 1'b0;
            else if (out_ready && out_valid)
            begin
                gap = ($urandom_range(3) == 0) ? pick_gap() : 0;
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                    out_ready <= 1'b1;
                end
            end
            else
                out_ready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        comp_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.kind = result_kind;
            got.temp = temperature;
            got.press = pressure;
            got.dz = divisor_zero;
            if (result_kind == CMD_TEMP)
                n_temp++;
            else
                n_press++;
            if (divisor_zero)
                n_dz++;
            sb.check_result(got);
        end
    end

    task automatic send_sample(logic c, logic [19:0] adc);
        int gap;
        gap = pick_gap();
        repeat (gap) @(posedge clk);
        in_valid <= 1'b1;
        cmd <= c;
        raw_sample <= adc;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(c, adc);
        in_valid <= 1'b0;
        // the block is busy after an accept and takes no new beat until it is idle again
        @(posedge clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // realistic trims with random jitter
    task automatic load_typical_trims();
        write_cfg(REG_TEMP_TRIM, {16'(50 + $urandom_range(15)),
                                  16'(26000 + $urandom_range(1000)),
                                  16'(27000 + $urandom_range(2000))});
        write_cfg(REG_PRESS_LOW, {16'(2800 + $urandom_range(600)),
                                  16'(3024),
                                  16'(-10600 + $urandom_range(300)),
                                  16'(35000 + $urandom_range(4000))});
        write_cfg(REG_PRESS_MID, {16'(-12000 + $urandom_range(600)),
                                  16'(-15 + $urandom_range(30)),
                                  16'(-7 + $urandom_range(14)),
                                  16'(140 + $urandom_range(60))});
        write_cfg(REG_PRESS_HIGH, 64'(16'(4000 + $urandom_range(3000))));
    endtask

    initial
    begin
        logic [19:0] adc;
        int k;
        sb = new();
        sb.clear();
        cycle_count = 0;
        hold_off = 1'b0;
        n_temp = 0;
        n_press = 0;
        n_dz = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_TEMP;
        raw_sample = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_TEMP_TRIM;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset trims: pressure before any temperature, zero divisor
        send_sample(CMD_PRESS, 20'h80000);
        send_sample(CMD_TEMP, 20'hFFFFF);
        send_sample(CMD_PRESS, 20'h00000);
        drain();

        // typical trims, sample extremes
        load_typical_trims();
        send_sample(CMD_PRESS, 20'h51000);
        foreach (adc[i])
        begin
            send_sample(CMD_TEMP, 20'h7E000 ^ (20'd1 << i));
            send_sample(CMD_PRESS, 20'h51000 ^ (20'd1 << i));
            if (i > 4)
                break;
        end
        send_sample(CMD_TEMP, 20'h00000);
        send_sample(CMD_PRESS, 20'hFFFFF);
        send_sample(CMD_TEMP, 20'hFFFFF);
        send_sample(CMD_PRESS, 20'h00000);
        drain();

        // all-ones and most-negative trims; out-of-range index is ignored
        write_cfg(REG_TEMP_TRIM, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cfg(REG_PRESS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cfg(REG_PRESS_MID, 64'h8000_8000_8000_8000);
        write_cfg(REG_PRESS_HIGH, 64'h0000_0000_0000_8000);
        write_cfg(3'd7, 64'h1234_5678_9ABC_DEF0);
        write_cfg(3'd4, '1);
        send_sample(CMD_TEMP, 20'hFFFFF);
        send_sample(CMD_PRESS, 20'h00000);
        send_sample(CMD_TEMP, 20'h00000);
        send_sample(CMD_PRESS, 20'hFFFFF);
        drain();

        // long receiver hold-off while the sender keeps offering
        load_typical_trims();
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            for (k = 0; k < 8; k++)
                send_sample(k[0], 20'($urandom));
        join
        drain();

        // random phases, each with its own trim setting
        for (int ph = 0; ph < 15; ph++)
        begin
            case ($urandom_range(3))
                0:
                begin
                    write_cfg(REG_TEMP_TRIM, {$urandom, $urandom});
                    write_cfg(REG_PRESS_LOW, {$urandom, $urandom});
                    write_cfg(REG_PRESS_MID, {$urandom, $urandom});
                    write_cfg(REG_PRESS_HIGH, 64'($urandom));
                end
                1:
                    write_cfg(REG_PRESS_LOW, {48'($urandom), 16'd0});
                default:
                    load_typical_trims();
            endcase
            for (k = 0; k < 100; k++)
            begin
                if ($urandom_range(9) < 8)
                    adc = 20'($urandom_range(20'h7FFFF, 20'h40000)) ^
                          20'($urandom_range(255));
                else
                    adc = 20'($urandom);
                send_sample(($urandom_range(2) != 0) ? CMD_PRESS : CMD_TEMP, adc);
            end
            drain();
        end

        $display("checked %0d beats: %0d temperature, %0d pressure, %0d zero divisor",
                 sb.n_checked, n_temp, n_press, n_dz);
        $display("trim sets ranged from reset zeros through extremes to random");
        if (sb.n_errors == 0 && sb.pending.size() == 0)
            $display("temp_press_compensation_test: PASS");
        else
            $display("temp_press_compensation_test: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/tpc_pkg.sv
hw/rtl/tpc_mul.sv
hw/rtl/tpc_div.sv
hw/rtl/temp_press_compensation.sv
tb/sv/temp_press_compensation_test.sv
